### src/ssm_pkg.sv
// ----------------------------------------------------------------------------
// Storage statistics merge package
// Shared widths, constants and record types for the statistics merge block.
// ----------------------------------------------------------------------------
package ssm_pkg;

    localparam int SIZE_W  = 32;
    localparam int COUNT_W = 64;
    localparam int NAME_W  = 32;
    localparam int CNT_W   = 16;
    localparam int SHIFT_W = 6;

    localparam int IN_DATA_W  = 448;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 480;

    localparam logic [CNT_W-1:0]   COUNT_MAX  = {CNT_W{1'b1}};
    localparam logic [COUNT_W-1:0] ALL_ONES64 = {COUNT_W{1'b1}};
    localparam logic [SHIFT_W-1:0] NO_GAP     = 6'd32;

    typedef struct packed {
        logic               start_new;
        logic               reply_failed;
        logic [SIZE_W-1:0]  block_size;
        logic [COUNT_W-1:0] free_blocks;
        logic [COUNT_W-1:0] avail_blocks;
        logic [COUNT_W-1:0] total_blocks;
        logic [COUNT_W-1:0] total_files;
        logic [COUNT_W-1:0] free_files;
        logic [NAME_W-1:0]  name_length_max;
        logic [COUNT_W-1:0] max_file_bytes;
    } reply_t;

    typedef struct packed {
        logic [SIZE_W-1:0]  block_size;
        logic [COUNT_W-1:0] free_blocks;
        logic [COUNT_W-1:0] avail_blocks;
        logic [COUNT_W-1:0] total_blocks;
        logic [COUNT_W-1:0] total_files;
        logic [COUNT_W-1:0] free_files;
        logic [NAME_W-1:0]  name_length;
        logic [COUNT_W-1:0] max_file_bytes;
        logic [CNT_W-1:0]   replies_done;
        logic [CNT_W-1:0]   replies_ok;
    } agg_t;

endpackage

### src/ssm_merge.sv
// ----------------------------------------------------------------------------
// Statistics merge step
// Computes the next aggregate from the current aggregate and one reply.
// ----------------------------------------------------------------------------
module ssm_merge (
    input  logic          min_mode,
    input  ssm_pkg::agg_t   agg,
    input  ssm_pkg::reply_t reply,
    output ssm_pkg::agg_t   agg_next
);
    import ssm_pkg::*;

    function automatic logic [4:0] low_index(input logic [SIZE_W-1:0] x);
        logic [4:0] idx;
        idx = 5'd0;
        for (int i = SIZE_W - 1; i >= 0; i--)
        begin
            if (x[i])
            begin
                idx = 5'(i);
            end
        end
        return idx;
    endfunction

    agg_t               base;
    logic [SIZE_W-1:0]  size_or;
    logic [SIZE_W-1:0]  size_rest;
    logic [SHIFT_W-1:0] gap;
    logic [SHIFT_W-1:0] sh;
    logic               agg_smaller;
    logic [COUNT_W-1:0] a_free;
    logic [COUNT_W-1:0] a_avail;
    logic [COUNT_W-1:0] a_total;
    logic [COUNT_W-1:0] r_free;
    logic [COUNT_W-1:0] r_avail;
    logic [COUNT_W-1:0] r_total;
    logic [COUNT_W:0]   files_sum;
    logic [COUNT_W:0]   ffree_sum;

    always_comb
    begin
        base = reply.start_new ? '0 : agg;

        size_or   = base.block_size | reply.block_size;
        size_rest = size_or & (size_or - 1'b1);
        if (size_rest == '0)
        begin
            gap = NO_GAP;
        end
        else
        begin
            gap = {1'b0, low_index(size_rest) - low_index(size_or)};
        end
        sh = (base.block_size != reply.block_size) ? gap : '0;
        agg_smaller = base.block_size < reply.block_size;

        a_free  = agg_smaller ? (base.free_blocks >> sh)  : base.free_blocks;
        a_avail = agg_smaller ? (base.avail_blocks >> sh) : base.avail_blocks;
        a_total = agg_smaller ? (base.total_blocks >> sh) : base.total_blocks;
        r_free  = agg_smaller ? reply.free_blocks  : (reply.free_blocks >> sh);
        r_avail = agg_smaller ? reply.avail_blocks : (reply.avail_blocks >> sh);
        r_total = agg_smaller ? reply.total_blocks : (reply.total_blocks >> sh);

        files_sum = {1'b0, base.total_files} + {1'b0, reply.total_files};
        ffree_sum = {1'b0, base.free_files} + {1'b0, reply.free_files};

        agg_next = base;
        if (!reply.reply_failed)
        begin
            if (base.replies_ok == '0)
            begin
                agg_next.block_size     = reply.block_size;
                agg_next.free_blocks    = reply.free_blocks;
                agg_next.avail_blocks   = reply.avail_blocks;
                agg_next.total_blocks   = reply.total_blocks;
                agg_next.total_files    = reply.total_files;
                agg_next.free_files     = reply.free_files;
                agg_next.name_length    = reply.name_length_max;
                agg_next.max_file_bytes = reply.max_file_bytes;
            end
            else
            begin
                agg_next.block_size = agg_smaller ? reply.block_size : base.block_size;
                if (min_mode)
                begin
                    if (a_avail > r_avail)
                    begin
                        agg_next.free_blocks  = r_free;
                        agg_next.avail_blocks = r_avail;
                    end
                    else
                    begin
                        agg_next.free_blocks  = a_free;
                        agg_next.avail_blocks = a_avail;
                    end
                end
                else
                begin
                    agg_next.free_blocks  = a_free + r_free;
                    agg_next.avail_blocks = a_avail + r_avail;
                end
                agg_next.total_blocks = a_total + r_total;
                agg_next.total_files  = files_sum[COUNT_W] ? ALL_ONES64
                                                           : files_sum[COUNT_W-1:0];
                agg_next.free_files   = ffree_sum[COUNT_W] ? ALL_ONES64
                                                           : ffree_sum[COUNT_W-1:0];
                if (reply.name_length_max < base.name_length)
                begin
                    agg_next.name_length = reply.name_length_max;
                end
                if (reply.max_file_bytes < base.max_file_bytes)
                begin
                    agg_next.max_file_bytes = reply.max_file_bytes;
                end
            end
            if (base.replies_ok != COUNT_MAX)
            begin
                agg_next.replies_ok = base.replies_ok + 1'b1;
            end
        end
        if (base.replies_done != COUNT_MAX)
        begin
            agg_next.replies_done = base.replies_done + 1'b1;
        end
    end

endmodule

### src/storage_stats_merge.sv
// ----------------------------------------------------------------------------
// Storage statistics merge
// Folds per-target statistics replies into one running aggregate.
// ----------------------------------------------------------------------------
// Replies arrive on the s_t* stream, one request per reply, and every reply
// produces one request on the m_t* stream holding the aggregate and the
// reply counters after that reply has been applied.
// The cfg_* channel writes the minimum-available mode bit; it is always ready
// and should only be written while no reply is in flight.
// A reply is captured in an input register and then merged into the aggregate
// registers, which present its result on m_t*. One reply per cycle is
// sustained while the receiver keeps m_tready high.
// The aggregate registers also serve as the output register. When the
// receiver stalls, the result holds, and one more reply can still be taken
// into the input register before s_tready drops.
// Reset clears the aggregate, the counters, the mode bit and both valid
// flags.
// ----------------------------------------------------------------------------
module storage_stats_merge (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic                           cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // block_size, free_blocks, avail_blocks, total_blocks, total_files,
    // free_files, name_length_max, max_file_bytes
    input  logic [ssm_pkg::IN_DATA_W-1:0]  s_tdata,
    // start_new, reply_failed
    input  logic [ssm_pkg::IN_USER_W-1:0]  s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // agg_block_size, agg_free_blocks, agg_avail_blocks, agg_total_blocks,
    // agg_total_files, agg_free_files, agg_name_length, agg_max_file_bytes,
    // replies_done, replies_ok
    output logic [ssm_pkg::OUT_DATA_W-1:0] m_tdata
);
    import ssm_pkg::*;

    logic   mode_reg;
    logic   in_valid_reg;
    reply_t in_reg;
    logic   out_valid_reg;
    agg_t   agg_reg;
    agg_t   agg_next;
    reply_t in_unpacked;
    logic   advance;
    logic   fire;

    assign cfg_ready = 1'b1;
    assign advance   = !out_valid_reg || m_tready;
    assign fire      = in_valid_reg && advance;
    assign s_tready  = !in_valid_reg || advance;
    assign m_tvalid  = out_valid_reg;

    always_comb
    begin
        in_unpacked.start_new       = s_tuser[0];
        in_unpacked.reply_failed    = s_tuser[1];
        in_unpacked.block_size      = s_tdata[31:0];
        in_unpacked.free_blocks     = s_tdata[95:32];
        in_unpacked.avail_blocks    = s_tdata[159:96];
        in_unpacked.total_blocks    = s_tdata[223:160];
        in_unpacked.total_files     = s_tdata[287:224];
        in_unpacked.free_files      = s_tdata[351:288];
        in_unpacked.name_length_max = s_tdata[383:352];
        in_unpacked.max_file_bytes  = s_tdata[447:384];
    end

    assign m_tdata = {agg_reg.replies_ok, agg_reg.replies_done,
                      agg_reg.max_file_bytes, agg_reg.name_length,
                      agg_reg.free_files, agg_reg.total_files,
                      agg_reg.total_blocks, agg_reg.avail_blocks,
                      agg_reg.free_blocks, agg_reg.block_size};

    ssm_merge u_merge (
        .min_mode (mode_reg),
        .agg      (agg_reg),
        .reply    (in_reg),
        .agg_next (agg_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= 1'b0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            agg_reg       <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                mode_reg <= cfg_data;
            end
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (fire)
            begin
                agg_reg <= agg_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_reg <= in_unpacked;
        end
    end

endmodule

### test/storage_stats_merge_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Storage statistics merge testbench
// Streams statistics replies into the merge block. A behavioral model of the
// running aggregate predicts the result that each accepted request must
// produce, and every result is checked field by field in arrival order. The
// run covers both merge modes, directed corner cases, random reply groups,
// and random back-pressure on both streams.
// ----------------------------------------------------------------------------
module storage_stats_merge_tb;

    import ssm_pkg::*;

    localparam bit MODE_SUM = 1'b0;
    localparam bit MODE_MIN = 1'b1;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic                  cfg_data = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [IN_USER_W-1:0]  s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    reply_t reply_q[$];
    agg_t   expect_q[$];
    reply_t cur_reply;
    agg_t   run_agg;
    bit     min_mode;
    int     send_idle_pct;
    int     sink_stall_pct;
    int     mismatches;

    storage_stats_merge u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        #(20_000_000);
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [SHIFT_W-1:0] bit_gap(logic [SIZE_W-1:0] x);
        int  i;
        int  first;
        bit  seen;
        seen  = 1'b0;
        first = 0;
        for (i = 0; i < SIZE_W; i++)
        begin
            if (x[i])
            begin
                if (seen)
                    return SHIFT_W'(i - first);
                seen  = 1'b1;
                first = i;
            end
        end
        return NO_GAP;
    endfunction

    function automatic logic [COUNT_W-1:0] sat_add(logic [COUNT_W-1:0] a,
                                                   logic [COUNT_W-1:0] b);
        logic [COUNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COUNT_W] ? ALL_ONES64 : s[COUNT_W-1:0];
    endfunction

    function automatic agg_t fold_reply(reply_t r);
        logic [COUNT_W-1:0] f;
        logic [COUNT_W-1:0] a;
        logic [COUNT_W-1:0] t;
        logic [SHIFT_W-1:0] sh;
        f = r.free_blocks;
        a = r.avail_blocks;
        t = r.total_blocks;
        if (r.start_new)
            run_agg = '0;
        if (!r.reply_failed)
        begin
            if (run_agg.replies_ok == '0)
            begin
                run_agg.block_size     = r.block_size;
                run_agg.free_blocks    = f;
                run_agg.avail_blocks   = a;
                run_agg.total_blocks   = t;
                run_agg.total_files    = r.total_files;
                run_agg.free_files     = r.free_files;
                run_agg.name_length    = r.name_length_max;
                run_agg.max_file_bytes = r.max_file_bytes;
            end
            else
            begin
                sh = '0;
                if (run_agg.block_size != r.block_size)
                    sh = bit_gap(run_agg.block_size | r.block_size);
                if (run_agg.block_size < r.block_size)
                begin
                    run_agg.block_size   = r.block_size;
                    run_agg.free_blocks  = run_agg.free_blocks >> sh;
                    run_agg.avail_blocks = run_agg.avail_blocks >> sh;
                    run_agg.total_blocks = run_agg.total_blocks >> sh;
                end
                else
                begin
                    f = f >> sh;
                    a = a >> sh;
                    t = t >> sh;
                end
                if (min_mode == MODE_MIN)
                begin
                    if (run_agg.avail_blocks > a)
                    begin
                        run_agg.free_blocks  = f;
                        run_agg.avail_blocks = a;
                    end
                end
                else
                begin
                    run_agg.free_blocks  = run_agg.free_blocks + f;
                    run_agg.avail_blocks = run_agg.avail_blocks + a;
                end
                run_agg.total_blocks = run_agg.total_blocks + t;
                run_agg.total_files  = sat_add(run_agg.total_files, r.total_files);
                run_agg.free_files   = sat_add(run_agg.free_files, r.free_files);
                if (r.name_length_max < run_agg.name_length)
                    run_agg.name_length = r.name_length_max;
                if (r.max_file_bytes < run_agg.max_file_bytes)
                    run_agg.max_file_bytes = r.max_file_bytes;
            end
            if (run_agg.replies_ok != COUNT_MAX)
                run_agg.replies_ok = run_agg.replies_ok + 1'b1;
        end
        if (run_agg.replies_done != COUNT_MAX)
            run_agg.replies_done = run_agg.replies_done + 1'b1;
        return run_agg;
    endfunction

    function automatic reply_t make_reply(bit start, bit failed, logic [31:0] bsize,
                                          logic [63:0] free, logic [63:0] avail,
                                          logic [63:0] total, logic [63:0] files,
                                          logic [63:0] ffree, logic [31:0] name,
                                          logic [63:0] maxb);
        reply_t r;
        r.start_new       = start;
        r.reply_failed    = failed;
        r.block_size      = bsize;
        r.free_blocks     = free;
        r.avail_blocks    = avail;
        r.total_blocks    = total;
        r.total_files     = files;
        r.free_files      = ffree;
        r.name_length_max = name;
        r.max_file_bytes  = maxb;
        return r;
    endfunction

    function automatic logic [COUNT_W-1:0] rand_count();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return ALL_ONES64;
            2: return ALL_ONES64 - $urandom_range(0, 15);
            3: return $urandom_range(0, 999);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [SIZE_W-1:0] rand_size();
        case ($urandom_range(0, 9))
            0, 1: return 32'd4096;
            2: return 32'd512;
            3: return $urandom_range(1, 32'h8000_0000);
            default: return 32'd1 << $urandom_range(0, 31);
        endcase
    endfunction

    function automatic logic [NAME_W-1:0] rand_name();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return $urandom_range(1, 255);
            default: return $urandom;
        endcase
    endfunction

    function automatic reply_t rand_reply(bit start, bit failed);
        return make_reply(start, failed, rand_size(), rand_count(), rand_count(),
                          rand_count(), rand_count(), rand_count(), rand_name(),
                          rand_count());
    endfunction

    // Groups of replies as one statistics request would produce them: a
    // start at the head of most groups, occasional failures, and rare stray
    // starts in the middle.
    task automatic queue_groups(int n);
        int k;
        int len;
        int j;
        bit s;
        k = 0;
        while (k < n)
        begin
            len = $urandom_range(1, 8);
            for (j = 0; j < len && k < n; j++)
            begin
                s = (j == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 19) == 0);
                reply_q.push_back(rand_reply(s, $urandom_range(0, 5) == 0));
                k++;
            end
        end
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (reply_q.size() != 0 || s_tvalid || expect_q.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_mode(bit v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        min_mode = v;
        cfg_valid <= 1'b0;
    endtask

    task automatic check_field(string label, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s mismatch, expected %h, got %h", $realtime, label, want,
                         got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expect_q.push_back(fold_reply(cur_reply));
            if (!s_tvalid || s_tready)
            begin
                if (reply_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    cur_reply = reply_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {cur_reply.max_file_bytes, cur_reply.name_length_max,
                                 cur_reply.free_files, cur_reply.total_files,
                                 cur_reply.total_blocks, cur_reply.avail_blocks,
                                 cur_reply.free_blocks, cur_reply.block_size};
                    s_tuser  <= {cur_reply.reply_failed, cur_reply.start_new};
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        agg_t got;
        agg_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                {got.replies_ok, got.replies_done, got.max_file_bytes, got.name_length,
                 got.free_files, got.total_files, got.total_blocks, got.avail_blocks,
                 got.free_blocks, got.block_size} = m_tdata;
                if (expect_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result with no request pending: %h", $realtime,
                                 m_tdata);
                end
                else
                begin
                    want = expect_q.pop_front();
                    check_field("agg_block_size", want.block_size, got.block_size);
                    check_field("agg_free_blocks", want.free_blocks, got.free_blocks);
                    check_field("agg_avail_blocks", want.avail_blocks, got.avail_blocks);
                    check_field("agg_total_blocks", want.total_blocks, got.total_blocks);
                    check_field("agg_total_files", want.total_files, got.total_files);
                    check_field("agg_free_files", want.free_files, got.free_files);
                    check_field("agg_name_length", want.name_length, got.name_length);
                    check_field("agg_max_file_bytes", want.max_file_bytes,
                                got.max_file_bytes);
                    check_field("replies_done", want.replies_done, got.replies_done);
                    check_field("replies_ok", want.replies_ok, got.replies_ok);
                end
            end
            m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    initial
    begin
        min_mode       = MODE_SUM;
        run_agg        = '0;
        mismatches     = 0;
        send_idle_pct  = 11;
        sink_stall_pct = 74;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        write_mode(MODE_SUM);
        // A failure ahead of any success leaves the aggregate at zero.
        reply_q.push_back(make_reply(0, 1, 32'h8000_0000, ALL_ONES64, ALL_ONES64,
                                     ALL_ONES64, ALL_ONES64, ALL_ONES64, '1, ALL_ONES64));
        reply_q.push_back(make_reply(1, 0, 4096, 1000, 800, 5000, 300, 200, 255,
                                     64'h1_0000_0000));
        reply_q.push_back(make_reply(0, 0, 4096, 24, 16, 100, ALL_ONES64 - 5, ALL_ONES64,
                                     128, 64'hFFFF_FFFF));
        reply_q.push_back(make_reply(0, 0, 1024, 4000, 4000, 4000, 1, 1, 300, ALL_ONES64));
        reply_q.push_back(make_reply(0, 0, 65536, 7, 3, 9, 0, 0, 0, 0));
        reply_q.push_back(make_reply(0, 0, 32'h8000_0000, ALL_ONES64, ALL_ONES64,
                                     ALL_ONES64, ALL_ONES64, ALL_ONES64, '1, ALL_ONES64));
        reply_q.push_back(make_reply(0, 0, 1, ALL_ONES64, ALL_ONES64, ALL_ONES64, 5, 5, 10,
                                     10));
        reply_q.push_back(make_reply(1, 1, 512, 1, 2, 3, 4, 5, 6, 7));
        reply_q.push_back(make_reply(0, 0, 8, 100, 90, 200, 10, 10, 40, 4000));
        // Block sizes that are not powers of two.
        reply_q.push_back(make_reply(0, 0, 12, 64, 64, 64, 20, 20, 50, 5000));
        reply_q.push_back(make_reply(0, 0, 32'h8000_0001, 1000, 1000, 1000, 1, 1, 30, 3000));
        reply_q.push_back(make_reply(0, 0, 32'h8000_0001, ALL_ONES64, ALL_ONES64,
                                     ALL_ONES64 - 1, ALL_ONES64, ALL_ONES64, '1, ALL_ONES64));
        drain();

        write_mode(MODE_MIN);
        reply_q.push_back(make_reply(1, 0, 4096, 500, 100, 1000, 10, 10, 200, 900));
        reply_q.push_back(make_reply(0, 0, 4096, 600, 200, 1000, 10, 10, 200, 900));
        reply_q.push_back(make_reply(0, 0, 4096, 700, 100, 1000, 10, 10, 200, 900));
        reply_q.push_back(make_reply(0, 0, 4096, 800, 50, 1000, 10, 10, 200, 900));
        reply_q.push_back(make_reply(0, 0, 16384, 64, 40, 64, 10, 10, 200, 900));
        reply_q.push_back(make_reply(0, 0, 1024, ALL_ONES64, 0, ALL_ONES64, 10, 10, 1, 1));
        reply_q.push_back(make_reply(0, 1, 4096, 9, 9, 9, 9, 9, 9, 9));
        reply_q.push_back(make_reply(1, 0, 2, 0, 0, 0, 0, 0, 0, 0));
        queue_groups(180);
        drain();

        write_mode(MODE_SUM);
        send_idle_pct  = 74;
        sink_stall_pct = 11;
        queue_groups(180);
        drain();

        write_mode(MODE_MIN);
        send_idle_pct  = 0;
        sink_stall_pct = 0;
        queue_groups(90);
        drain();
        queue_groups(90);
        drain();

        if (mismatches == 0 && expect_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
